// ===== rtl/rbcc_pkg.sv =====
// Shared types, constants and helpers of the roaring bitmap compliance checker.
package rbcc_pkg;

    // Default capacity of the container stores.
    localparam int unsigned MAX_CONTAINERS_DFLT = 4096;

    // Format constants.
    localparam logic [31:0] COOKIE_NORUN = 32'd12346;
    localparam logic [15:0] COOKIE_RUN   = 16'd12347;
    localparam logic [16:0] ARRAY_LIMIT  = 17'd4096;
    localparam logic [13:0] BITSET_BYTES = 14'd8192;
    localparam logic [16:0] OFFSETS_FROM = 17'd4;
    localparam logic [47:0] POS_MAX      = 48'hFFFF_FFFF_FFFF;

    // Status codes of a result.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COOKIE   = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    // Parse phases, one-hot.
    typedef enum logic [12:0] {
        PH_COOKIE  = 13'b0000000000001,
        PH_COUNT   = 13'b0000000000010,
        PH_FLAGS   = 13'b0000000000100,
        PH_KEYCARD = 13'b0000000001000,
        PH_OFFCHK  = 13'b0000000010000,
        PH_OFFSKIP = 13'b0000000100000,
        PH_NRUNS   = 13'b0000001000000,
        PH_BODY    = 13'b0000010000000,
        PH_NUMKEYS = 13'b0000100000000,
        PH_KEY     = 13'b0001000000000,
        PH_DONE    = 13'b0010000000000,
        PH_STOP    = 13'b0100000000000,
        PH_ENTER   = 13'b1000000000000
    } t_phase;

    // One result beat.
    typedef struct packed {
        logic        compliant;
        logic [1:0]  status;
        logic [47:0] block_size;
        logic        size_valid;
    } t_result;

    // Body length of a container from its stored cardinality minus one.
    function automatic logic [13:0] body_len(input logic [15:0] card);
        logic [16:0] cnt;
        cnt = {1'b0, card} + 17'd1;
        if (cnt <= ARRAY_LIMIT) begin
            body_len = {cnt[12:0], 1'b0};
        end else begin
            body_len = BITSET_BYTES;
        end
    endfunction

endpackage

// ===== rtl/roaring_bitmap_compliance_check_top.sv =====
// Top level of the roaring bitmap compliance checker with its result register.
//
// The block takes a serialized roaring bitmap one byte per beat and accepts a
// byte on every clock cycle unless a result waits and the consumer stalls; the
// result of a payload appears in the output register on the cycle after its last
// byte is taken, and the next payload may follow at once. The sustained rate of
// one byte per cycle while the output does not stall is set by the cardinality
// and run-flag memories, which see at most one write and one registered read
// per cycle, read one container ahead of the parse. The memories need no
// clearing after reset. bitmap_width is sampled at each payload's first byte.
module roaring_bitmap_compliance_check_top #(
    parameter int unsigned MAX_CONTAINERS = rbcc_pkg::MAX_CONTAINERS_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_bitmap_width,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_compliant,
    output logic [1:0]  o_status,
    output logic [47:0] o_block_size,
    output logic        o_size_valid
);

    localparam int unsigned AW     = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1;
    localparam int unsigned FDEPTH = (MAX_CONTAINERS + 7) / 8;
    localparam int unsigned FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

    logic              accept;
    logic              res_valid;
    rbcc_pkg::t_result res;
    logic              card_we;
    logic [AW-1:0]     card_waddr;
    logic [15:0]       card_wdata;
    logic [AW-1:0]     card_raddr;
    logic [15:0]       card;
    logic              flag_we;
    logic [FAW-1:0]    flag_waddr;
    logic [7:0]        flag_wdata;
    logic [FAW-1:0]    flag_raddr;
    logic [7:0]        flag_row;
    logic              r_out_valid;
    rbcc_pkg::t_result r_out;

    // A byte is taken unless a result waits and the consumer stalls.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    rbcc_parse #(
        .MAX_CONTAINERS (MAX_CONTAINERS),
        .AW             (AW),
        .FAW            (FAW)
    ) u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_bitmap_width (i_cfg_bitmap_width),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_result_valid     (res_valid),
        .o_result           (res),
        .o_card_we          (card_we),
        .o_card_waddr       (card_waddr),
        .o_card_wdata       (card_wdata),
        .o_card_raddr       (card_raddr),
        .i_card             (card),
        .o_flag_we          (flag_we),
        .o_flag_waddr       (flag_waddr),
        .o_flag_wdata       (flag_wdata),
        .o_flag_raddr       (flag_raddr),
        .i_flag_row         (flag_row)
    );

    rbcc_store #(
        .DEPTH  (MAX_CONTAINERS),
        .FDEPTH (FDEPTH),
        .AW     (AW),
        .FAW    (FAW)
    ) u_store (
        .i_clk        (i_clk),
        .i_card_we    (card_we),
        .i_card_waddr (card_waddr),
        .i_card_wdata (card_wdata),
        .i_card_raddr (card_raddr),
        .o_card       (card),
        .i_flag_we    (flag_we),
        .i_flag_waddr (flag_waddr),
        .i_flag_wdata (flag_wdata),
        .i_flag_raddr (flag_raddr),
        .o_flag_row   (flag_row)
    );

    // Output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_compliant  = r_out.compliant;
    assign o_status     = r_out.status;
    assign o_block_size = r_out.block_size;
    assign o_size_valid = r_out.size_valid;

endmodule

// ===== rtl/rbcc_store.sv =====
// Cardinality and run-flag memories with write-to-read forwarding.
module rbcc_store #(
    parameter int unsigned DEPTH  = rbcc_pkg::MAX_CONTAINERS_DFLT,
    parameter int unsigned FDEPTH = (rbcc_pkg::MAX_CONTAINERS_DFLT + 7) / 8,
    parameter int unsigned AW     = 12,
    parameter int unsigned FAW    = 9
) (
    input  logic           i_clk,
    input  logic           i_card_we,
    input  logic [AW-1:0]  i_card_waddr,
    input  logic [15:0]    i_card_wdata,
    input  logic [AW-1:0]  i_card_raddr,
    output logic [15:0]    o_card,
    input  logic           i_flag_we,
    input  logic [FAW-1:0] i_flag_waddr,
    input  logic [7:0]     i_flag_wdata,
    input  logic [FAW-1:0] i_flag_raddr,
    output logic [7:0]     o_flag_row
);

    logic [15:0] r_card_mem [DEPTH];
    logic [7:0]  r_flag_mem [FDEPTH];
    logic [15:0] r_card;
    logic [7:0]  r_flag_row;

    // Cardinality store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_card_we) begin
            r_card_mem[i_card_waddr] <= i_card_wdata;
        end
        if (i_card_we && i_card_waddr == i_card_raddr) begin
            r_card <= i_card_wdata;
        end else begin
            r_card <= r_card_mem[i_card_raddr];
        end
    end

    // Run-flag store, eight flags to a row.
    always_ff @(posedge i_clk) begin
        if (i_flag_we) begin
            r_flag_mem[i_flag_waddr] <= i_flag_wdata;
        end
        if (i_flag_we && i_flag_waddr == i_flag_raddr) begin
            r_flag_row <= i_flag_wdata;
        end else begin
            r_flag_row <= r_flag_mem[i_flag_raddr];
        end
    end

    assign o_card     = r_card;
    assign o_flag_row = r_flag_row;

endmodule

// ===== rtl/rbcc_parse.sv =====
// Byte-serial parse sequencer: headers, offset check, body skipping and the verdict.
module rbcc_parse #(
    parameter int unsigned MAX_CONTAINERS = rbcc_pkg::MAX_CONTAINERS_DFLT,
    parameter int unsigned AW             = 12,
    parameter int unsigned FAW            = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_bitmap_width,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_result_valid,
    output rbcc_pkg::t_result o_result,
    output logic              o_card_we,
    output logic [AW-1:0]     o_card_waddr,
    output logic [15:0]       o_card_wdata,
    output logic [AW-1:0]     o_card_raddr,
    input  logic [15:0]       i_card,
    output logic              o_flag_we,
    output logic [FAW-1:0]    o_flag_waddr,
    output logic [7:0]        o_flag_wdata,
    output logic [FAW-1:0]    o_flag_raddr,
    input  logic [7:0]        i_flag_row
);

    localparam logic [32:0] MAX_N = 33'(MAX_CONTAINERS);

    logic             r_cfg_width;
    rbcc_pkg::t_phase r_phase, n_phase;
    logic             r_wide, n_wide;
    logic [47:0]      r_pos, n_pos;
    logic [31:0]      r_rel, n_rel;
    logic [63:0]      r_asm, n_asm;
    logic [3:0]       r_cnt, n_cnt;
    logic [31:0]      r_cookie, n_cookie;
    logic [16:0]      r_total, n_total;
    logic [16:0]      r_idx, n_idx;
    logic [31:0]      r_exp, n_exp;
    logic [47:0]      r_req_end, n_req_end;
    logic [31:0]      r_skip, n_skip;
    logic [63:0]      r_keys, n_keys;
    logic [47:0]      r_bstart, n_bstart;
    logic [2:0]       r_verdict, n_verdict;
    logic [31:0]      r_sum, n_sum;

    rbcc_pkg::t_phase  ph;
    logic              wide_e;
    logic [63:0]       asm_new;
    logic [3:0]        cnt_p1;
    logic              do_finish;
    logic              do_enter;
    logic              do_next;
    logic [32:0]       count_n;
    logic              norun;
    logic              hdr_in;
    rbcc_pkg::t_result res;

    // Configuration register; sampled at the first byte of a payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= 1'b0;
        end else if (i_cfg_we) begin
            r_cfg_width <= i_cfg_bitmap_width;
        end
    end

    // Next-state logic for one accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_wide    = r_wide;
        n_pos     = r_pos;
        n_rel     = r_rel;
        n_asm     = r_asm;
        n_cnt     = r_cnt;
        n_cookie  = r_cookie;
        n_total   = r_total;
        n_idx     = r_idx;
        n_exp     = r_exp;
        n_req_end = r_req_end;
        n_skip    = r_skip;
        n_keys    = r_keys;
        n_bstart  = r_bstart;
        n_verdict = r_verdict;
        n_sum     = r_sum;
        do_finish = 1'b0;
        do_enter  = 1'b0;
        do_next   = 1'b0;
        count_n   = '0;
        o_card_we    = 1'b0;
        o_card_wdata = '0;
        o_flag_we    = 1'b0;

        // Field assembly of little-endian bytes.
        cnt_p1  = r_cnt + 4'd1;
        asm_new = (r_cnt == 4'd0) ? 64'd0 : r_asm;
        for (int k = 0; k < 8; k++) begin
            if (r_cnt[2:0] == 3'(k)) begin
                asm_new[8*k +: 8] = i_data_byte;
            end
        end

        if (r_pos == 48'd0) begin
            wide_e = r_cfg_width;
            ph     = r_cfg_width ? rbcc_pkg::PH_NUMKEYS : rbcc_pkg::PH_COOKIE;
        end else begin
            wide_e = r_wide;
            ph     = r_phase;
        end

        if (i_accept) begin
            n_wide  = wide_e;
            n_phase = ph;
            if (r_pos != rbcc_pkg::POS_MAX) begin
                n_pos = r_pos + 48'd1;
                n_rel = r_rel + 32'd1;
            end

            case (ph)
                rbcc_pkg::PH_NUMKEYS: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd8) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd8) begin
                        n_keys = asm_new;
                        if (asm_new == 64'd0) begin
                            n_req_end = n_pos;
                            n_phase   = rbcc_pkg::PH_DONE;
                        end else begin
                            n_phase = rbcc_pkg::PH_KEY;
                        end
                    end
                end
                rbcc_pkg::PH_KEY: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd4) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd4) begin
                        n_bstart = n_pos;
                        n_rel    = 32'd0;
                        n_phase  = rbcc_pkg::PH_COOKIE;
                    end
                end
                rbcc_pkg::PH_COOKIE: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd4) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd4) begin
                        n_cookie = asm_new[31:0];
                        count_n  = {16'd0, asm_new[31:16]} + 33'd1;
                        if (asm_new[31:0] == rbcc_pkg::COOKIE_NORUN) begin
                            n_phase = rbcc_pkg::PH_COUNT;
                        end else if (asm_new[15:0] == rbcc_pkg::COOKIE_RUN) begin
                            if (count_n > MAX_N) begin
                                n_verdict = r_verdict | {1'b0, rbcc_pkg::ST_CAPACITY};
                                n_phase   = rbcc_pkg::PH_STOP;
                            end else begin
                                n_total = count_n[16:0];
                                n_idx   = '0;
                                n_sum   = '0;
                                n_phase = rbcc_pkg::PH_FLAGS;
                            end
                        end else begin
                            n_verdict = r_verdict | {1'b0, rbcc_pkg::ST_COOKIE};
                            n_phase   = rbcc_pkg::PH_STOP;
                        end
                    end
                end
                rbcc_pkg::PH_COUNT: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd4) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd4) begin
                        count_n = {1'b0, asm_new[31:0]};
                        if (count_n == 33'd0) begin
                            do_finish = 1'b1;
                        end else if (count_n > MAX_N) begin
                            n_verdict = r_verdict | {1'b0, rbcc_pkg::ST_CAPACITY};
                            n_phase   = rbcc_pkg::PH_STOP;
                        end else begin
                            n_total = count_n[16:0];
                            n_idx   = '0;
                            n_sum   = '0;
                            n_phase = rbcc_pkg::PH_KEYCARD;
                        end
                    end
                end
                rbcc_pkg::PH_FLAGS: begin
                    // One byte carries eight run flags.
                    o_flag_we = 1'b1;
                    n_idx     = r_idx + 17'd1;
                    if ({n_idx, 3'b000} >= {3'b000, r_total}) begin
                        n_idx   = '0;
                        n_phase = rbcc_pkg::PH_KEYCARD;
                    end
                end
                rbcc_pkg::PH_KEYCARD: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd4) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd4) begin
                        o_card_we    = 1'b1;
                        o_card_wdata = asm_new[31:16];
                        n_sum = r_sum + 32'(rbcc_pkg::body_len(asm_new[31:16]));
                        n_idx = r_idx + 17'd1;
                        if (n_idx >= r_total) begin
                            n_idx = '0;
                            if (r_cookie == rbcc_pkg::COOKIE_NORUN) begin
                                n_req_end = 48'(n_rel) + 48'(n_sum);
                                n_exp     = n_rel + 32'({r_total, 2'b00});
                                n_phase   = rbcc_pkg::PH_OFFCHK;
                            end else if (r_total >= rbcc_pkg::OFFSETS_FROM) begin
                                n_skip  = 32'({r_total, 2'b00});
                                n_phase = rbcc_pkg::PH_OFFSKIP;
                            end else begin
                                do_enter = 1'b1;
                            end
                        end
                    end
                end
                rbcc_pkg::PH_OFFCHK: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd4) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd4) begin
                        if (asm_new[31:0] != r_exp) begin
                            n_verdict = r_verdict | 3'b100;
                            n_phase   = wide_e ? rbcc_pkg::PH_STOP : rbcc_pkg::PH_DONE;
                        end else begin
                            n_exp = r_exp + 32'(rbcc_pkg::body_len(i_card));
                            n_idx = r_idx + 17'd1;
                            if (n_idx >= r_total) begin
                                n_skip  = r_sum;
                                n_phase = rbcc_pkg::PH_BODY;
                                if (r_sum == 32'd0) begin
                                    do_finish = 1'b1;
                                end
                            end
                        end
                    end
                end
                rbcc_pkg::PH_OFFSKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        do_enter = 1'b1;
                    end
                end
                rbcc_pkg::PH_ENTER: begin
                    // Container choice resolved with the stored flag and cardinality.
                    if (i_flag_row[r_idx[2:0]]) begin
                        n_asm   = asm_new;
                        n_cnt   = cnt_p1;
                        n_phase = rbcc_pkg::PH_NRUNS;
                    end else begin
                        n_skip  = 32'(rbcc_pkg::body_len(i_card)) - 32'd1;
                        n_phase = rbcc_pkg::PH_BODY;
                    end
                end
                rbcc_pkg::PH_NRUNS: begin
                    n_asm = asm_new;
                    n_cnt = (cnt_p1 >= 4'd2) ? 4'd0 : cnt_p1;
                    if (cnt_p1 >= 4'd2) begin
                        n_skip = 32'({asm_new[15:0], 2'b00});
                        if (asm_new[15:0] == 16'd0) begin
                            do_next = 1'b1;
                        end else begin
                            n_phase = rbcc_pkg::PH_BODY;
                        end
                    end
                end
                rbcc_pkg::PH_BODY: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        if (r_cookie == rbcc_pkg::COOKIE_NORUN) begin
                            do_finish = 1'b1;
                        end else begin
                            do_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Step to a container; the flag lookup waits for the next byte.
            if (do_next) begin
                n_idx = r_idx + 17'd1;
            end
            if (do_next || do_enter) begin
                if (n_idx >= r_total) begin
                    do_finish = 1'b1;
                end else begin
                    n_phase = rbcc_pkg::PH_ENTER;
                end
            end

            // End of one bitmap or bucket.
            if (do_finish) begin
                if (!wide_e) begin
                    n_req_end = n_pos;
                    n_phase   = rbcc_pkg::PH_DONE;
                end else begin
                    n_keys = r_keys - 64'd1;
                    if (n_keys == 64'd0) begin
                        n_req_end = n_pos;
                        n_phase   = rbcc_pkg::PH_DONE;
                    end else begin
                        n_phase = rbcc_pkg::PH_KEY;
                    end
                end
            end
        end

        // Verdict of the payload as it stands after this byte.
        norun  = n_cookie == rbcc_pkg::COOKIE_NORUN;
        hdr_in = n_phase == rbcc_pkg::PH_KEYCARD || n_phase == rbcc_pkg::PH_OFFCHK
              || n_phase == rbcc_pkg::PH_BODY;
        res.compliant  = 1'b0;
        res.status     = n_verdict[1:0];
        res.block_size = '0;
        res.size_valid = 1'b0;
        if (n_verdict[1:0] != rbcc_pkg::ST_OK) begin
            res.status = n_verdict[1:0];
        end else if (n_verdict[2]) begin
            if (n_wide) begin
                res.block_size = n_bstart;
                res.size_valid = 1'b1;
            end else begin
                res.block_size = n_req_end;
                res.size_valid = n_req_end <= n_pos;
            end
        end else if (n_phase == rbcc_pkg::PH_DONE) begin
            res.compliant  = 1'b1;
            res.block_size = n_req_end;
            res.size_valid = 1'b1;
        end else if (n_wide) begin
            if (norun && hdr_in) begin
                res.block_size = n_bstart;
                res.size_valid = 1'b1;
            end else begin
                res.status = rbcc_pkg::ST_SHORT;
            end
        end else if (n_phase == rbcc_pkg::PH_COOKIE || n_phase == rbcc_pkg::PH_COUNT) begin
            res.status = rbcc_pkg::ST_SHORT;
        end else if (!norun) begin
            res.compliant  = 1'b1;
            res.block_size = n_pos;
        end else if (n_phase == rbcc_pkg::PH_OFFCHK || n_phase == rbcc_pkg::PH_BODY) begin
            res.block_size = n_req_end;
            res.size_valid = n_req_end <= n_pos;
        end else begin
            res.block_size = n_pos;
        end

        // The last byte restarts the parse.
        if (i_accept && i_last_byte) begin
            n_phase   = rbcc_pkg::PH_COOKIE;
            n_pos     = '0;
            n_rel     = '0;
            n_asm     = '0;
            n_cnt     = '0;
            n_cookie  = '0;
            n_total   = '0;
            n_idx     = '0;
            n_exp     = '0;
            n_req_end = '0;
            n_skip    = '0;
            n_keys    = '0;
            n_bstart  = '0;
            n_verdict = '0;
            n_sum     = '0;
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rbcc_pkg::PH_COOKIE;
            r_wide    <= 1'b0;
            r_pos     <= '0;
            r_rel     <= '0;
            r_asm     <= '0;
            r_cnt     <= '0;
            r_cookie  <= '0;
            r_total   <= '0;
            r_idx     <= '0;
            r_exp     <= '0;
            r_req_end <= '0;
            r_skip    <= '0;
            r_keys    <= '0;
            r_bstart  <= '0;
            r_verdict <= '0;
            r_sum     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_wide    <= n_wide;
            r_pos     <= n_pos;
            r_rel     <= n_rel;
            r_asm     <= n_asm;
            r_cnt     <= n_cnt;
            r_cookie  <= n_cookie;
            r_total   <= n_total;
            r_idx     <= n_idx;
            r_exp     <= n_exp;
            r_req_end <= n_req_end;
            r_skip    <= n_skip;
            r_keys    <= n_keys;
            r_bstart  <= n_bstart;
            r_verdict <= n_verdict;
            r_sum     <= n_sum;
        end
    end

    // Store addressing: reads follow the next container index.
    assign o_card_waddr   = AW'(r_idx);
    assign o_card_raddr   = AW'(n_idx);
    assign o_flag_waddr   = FAW'(r_idx);
    assign o_flag_wdata   = i_data_byte;
    assign o_flag_raddr   = FAW'(n_idx >> 3);
    assign o_result_valid = i_accept && i_last_byte;
    assign o_result       = res;

endmodule

// ===== tb/sv/rbcc_scoreboard.sv =====
// Checker of the roaring bitmap compliance checker: it predicts every result and compares it.
module rbcc_scoreboard
    import rbcc_pkg::*;
#(
    parameter int unsigned MAX_CONTAINERS = MAX_CONTAINERS_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_bitmap_width,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_compliant,
    input  logic [1:0]  i_status,
    input  logic [47:0] i_block_size,
    input  logic        i_size_valid,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state of the prediction.
    logic        width_reg;
    logic        wide;
    t_phase      phase;
    logic [63:0] byte_pos;
    logic [63:0] field_acc;
    int          field_cnt;
    logic [31:0] cookie;
    logic [31:0] cont_total;
    logic [31:0] cont_idx;
    logic [15:0] card_mem [MAX_CONTAINERS];
    logic        run_mem [MAX_CONTAINERS];
    logic [31:0] next_offset;
    logic [63:0] end_pos;
    logic [31:0] skip_left;
    logic [63:0] keys_left;
    logic [63:0] bucket_pos;
    logic [2:0]  verdict;
    logic [31:0] body_total;

    t_result     results_due[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = results_due.size();

    // Body bytes of a container without run flag.
    function automatic logic [31:0] cont_bytes(input logic [31:0] idx);
        logic [31:0] cnt;
        cnt = (idx < MAX_CONTAINERS ? {16'd0, card_mem[idx]} : 32'd0) + 32'd1;
        return (cnt <= 32'(ARRAY_LIMIT)) ? 2 * cnt : 32'(BITSET_BYTES);
    endfunction

    // Collects one byte of a little-endian field; returns 1 when the field is complete.
    function automatic bit gather(input logic [7:0] b, input int nbytes);
        if (field_cnt == 0) field_acc = '0;
        field_acc = field_acc | (64'(b) << (8 * (field_cnt & 7)));
        field_cnt++;
        if (field_cnt >= nbytes) begin
            field_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_parse();
        phase = PH_COOKIE;
        byte_pos = '0; field_acc = '0; field_cnt = 0;
        cookie = '0; cont_total = '0; cont_idx = '0;
        next_offset = '0; end_pos = '0; skip_left = '0;
        keys_left = '0; bucket_pos = '0; verdict = '0; body_total = '0;
    endtask

    task automatic close_bucket();
        if (!wide) begin
            end_pos = byte_pos;
            phase = PH_DONE;
        end else begin
            keys_left = keys_left - 1;
            if (keys_left == 0) begin
                end_pos = byte_pos;
                phase = PH_DONE;
            end else begin
                phase = PH_KEY;
            end
        end
    endtask

    task automatic open_container();
        if (cont_idx >= cont_total) begin
            close_bucket();
        end else if (cont_idx < MAX_CONTAINERS && run_mem[cont_idx]) begin
            phase = PH_NRUNS;
        end else begin
            skip_left = cont_bytes(cont_idx);
            phase = PH_BODY;
        end
    endtask

    task automatic abort(input logic [1:0] st);
        verdict[1:0] = verdict[1:0] | st;
        phase = PH_STOP;
    endtask

    task automatic start_containers(input logic [63:0] n, input bit run);
        if (n > 64'(MAX_CONTAINERS)) begin
            abort(ST_CAPACITY);
        end else begin
            cont_total = n[31:0];
            cont_idx = '0;
            body_total = '0;
            phase = run ? PH_FLAGS : PH_KEYCARD;
        end
    endtask

    // Advances the parse by one byte.
    task automatic parse_byte(input logic [7:0] b);
        logic [31:0] rel;
        logic [31:0] c;
        case (phase)
            PH_NUMKEYS: begin
                if (gather(b, 8)) begin
                    keys_left = field_acc;
                    if (keys_left == 0) begin
                        end_pos = byte_pos;
                        phase = PH_DONE;
                    end else begin
                        phase = PH_KEY;
                    end
                end
            end
            PH_KEY: begin
                if (gather(b, 4)) begin
                    bucket_pos = byte_pos;
                    phase = PH_COOKIE;
                end
            end
            PH_COOKIE: begin
                if (gather(b, 4)) begin
                    cookie = field_acc[31:0];
                    if (cookie == COOKIE_NORUN) begin
                        phase = PH_COUNT;
                    end else if (cookie[15:0] == COOKIE_RUN) begin
                        start_containers(64'(cookie[31:16]) + 64'd1, 1'b1);
                    end else begin
                        abort(ST_COOKIE);
                    end
                end
            end
            PH_COUNT: begin
                if (gather(b, 4)) begin
                    if (field_acc == 0) close_bucket();
                    else start_containers(field_acc, 1'b0);
                end
            end
            PH_FLAGS: begin
                for (int j = 0; j < 8; j++) begin
                    c = cont_idx * 8 + j;
                    if (c < cont_total && c < MAX_CONTAINERS) run_mem[c] = b[j];
                end
                cont_idx++;
                if (cont_idx * 8 >= cont_total) begin
                    cont_idx = '0;
                    phase = PH_KEYCARD;
                end
            end
            PH_KEYCARD: begin
                if (gather(b, 4)) begin
                    if (cont_idx < MAX_CONTAINERS) card_mem[cont_idx] = field_acc[31:16];
                    body_total = body_total + cont_bytes(cont_idx);
                    cont_idx++;
                    if (cont_idx >= cont_total) begin
                        rel = 32'(byte_pos - bucket_pos);
                        cont_idx = '0;
                        if (cookie == COOKIE_NORUN) begin
                            end_pos = 64'(rel) + 64'(body_total);
                            next_offset = rel + 4 * cont_total;
                            phase = PH_OFFCHK;
                        end else if (cont_total >= 32'(OFFSETS_FROM)) begin
                            skip_left = 4 * cont_total;
                            phase = PH_OFFSKIP;
                        end else begin
                            open_container();
                        end
                    end
                end
            end
            PH_OFFCHK: begin
                if (gather(b, 4)) begin
                    if (field_acc[31:0] != next_offset) begin
                        verdict[2] = 1'b1;
                        phase = wide ? PH_STOP : PH_DONE;
                    end else begin
                        next_offset = next_offset + cont_bytes(cont_idx);
                        cont_idx++;
                        if (cont_idx >= cont_total) begin
                            skip_left = body_total;
                            phase = PH_BODY;
                            if (skip_left == 0) close_bucket();
                        end
                    end
                end
            end
            PH_OFFSKIP: begin
                skip_left--;
                if (skip_left == 0) open_container();
            end
            PH_NRUNS: begin
                if (gather(b, 2)) begin
                    skip_left = 4 * {16'd0, field_acc[15:0]};
                    if (skip_left == 0) begin
                        cont_idx++;
                        open_container();
                    end else begin
                        phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                skip_left--;
                if (skip_left == 0) begin
                    if (cookie == COOKIE_NORUN) begin
                        close_bucket();
                    end else begin
                        cont_idx++;
                        open_container();
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Result of a payload that ends at the current byte.
    function automatic t_result payload_verdict();
        t_result r;
        logic [1:0] st;
        bit norun;
        bit in_hdr;
        r = '0;
        st = verdict[1:0];
        norun = (cookie == COOKIE_NORUN);
        in_hdr = (phase == PH_KEYCARD || phase == PH_OFFCHK || phase == PH_BODY);
        if (st != ST_OK) begin
        end else if (verdict[2]) begin
            if (wide) begin
                r.block_size = bucket_pos[47:0];
                r.size_valid = 1'b1;
            end else begin
                r.block_size = end_pos[47:0];
                r.size_valid = (end_pos <= byte_pos);
            end
        end else if (phase == PH_DONE) begin
            r.compliant = 1'b1;
            r.block_size = end_pos[47:0];
            r.size_valid = 1'b1;
        end else if (wide) begin
            if (norun && in_hdr) begin
                r.block_size = bucket_pos[47:0];
                r.size_valid = 1'b1;
            end else begin
                st = ST_SHORT;
            end
        end else if (phase == PH_COOKIE || phase == PH_COUNT) begin
            st = ST_SHORT;
        end else if (!norun) begin
            r.compliant = 1'b1;
            r.block_size = byte_pos[47:0];
        end else if (phase == PH_OFFCHK || phase == PH_BODY) begin
            r.block_size = end_pos[47:0];
            r.size_valid = (end_pos <= byte_pos);
        end else begin
            r.block_size = byte_pos[47:0];
        end
        r.status = st;
        return r;
    endfunction

    // Watch both channels and the register port.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            width_reg = 1'b0;
            wide = 1'b0;
            clear_parse();
            results_due.delete();
            errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with no result due");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (i_compliant !== want.compliant) begin
                        $error("compliant: expected %0d, got %0d", want.compliant, i_compliant);
                        errors++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        errors++;
                    end
                    if (i_block_size !== want.block_size) begin
                        $error("block_size: expected %0d, got %0d",
                               want.block_size, i_block_size);
                        errors++;
                    end
                    if (i_size_valid !== want.size_valid) begin
                        $error("size_valid: expected %0d, got %0d",
                               want.size_valid, i_size_valid);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (byte_pos == 0) begin
                    wide = width_reg;
                    phase = wide ? PH_NUMKEYS : PH_COOKIE;
                end
                if (byte_pos < 64'(POS_MAX)) byte_pos++;
                parse_byte(i_data_byte);
                if (i_last_byte) begin
                    results_due.push_back(payload_verdict());
                    clear_parse();
                end
            end
            if (i_cfg_we) width_reg = i_cfg_bitmap_width;
        end
    end

endmodule

// ===== tb/sv/tb_roaring_bitmap_compliance_check_top.sv =====
// Testbench top of the roaring bitmap compliance checker: clock, reset, stimulus and verdict.
module tb_roaring_bitmap_compliance_check_top;
    import rbcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_bitmap_width;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_compliant;
    logic [1:0]  o_status;
    logic [47:0] o_block_size;
    logic        o_size_valid;

    int          errors;
    int          pending;
    int          send_idle_pct;
    int          stall_pct;
    bit          hold_req;
    bit          hold_taken;
    int          hold_left;
    int          cycles;
    logic [7:0]  payload[$];

    always #5 i_clk = ~i_clk;

    roaring_bitmap_compliance_check_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_bitmap_width (i_cfg_bitmap_width),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_compliant        (o_compliant),
        .o_status           (o_status),
        .o_block_size       (o_block_size),
        .o_size_valid       (o_size_valid)
    );

    rbcc_scoreboard u_scoreboard (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_bitmap_width (i_cfg_bitmap_width),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_compliant        (o_compliant),
        .i_status           (o_status),
        .i_block_size       (o_block_size),
        .i_size_valid       (o_size_valid),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    // Receiver stall, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            hold_taken = 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("roaring_bitmap_compliance_check_top test failed");
            $finish;
        end
    end

    task automatic push_le(input logic [63:0] v, input int nbytes);
        for (int k = 0; k < nbytes; k++) payload.push_back(v[8*k +: 8]);
    endtask

    task automatic push_noise(input int nbytes);
        for (int k = 0; k < nbytes; k++) payload.push_back(8'($urandom));
    endtask

    // Appends one 32-bit bitmap with n containers; big gives the first one a bitset body unless it has a run flag.
    task automatic push_bitmap(input bit run, input int n, input bit corrupt, input bit big);
        logic [15:0] cards[];
        bit          flags[];
        logic [7:0]  fb;
        logic [31:0] off;
        int          bytes;
        int          bad;
        int          nruns;
        cards = new[n];
        flags = new[n];
        bad = $urandom_range(0, (n > 0) ? n - 1 : 0);
        if (!run) begin
            push_le(64'(COOKIE_NORUN), 4);
            push_le(64'(n), 4);
        end else begin
            push_le({32'd0, 16'(n - 1), COOKIE_RUN}, 4);
            for (int i = 0; i < (n + 7) / 8; i++) begin
                fb = 8'($urandom);
                payload.push_back(fb);
                for (int j = 0; j < 8; j++) if (i * 8 + j < n) flags[i * 8 + j] = fb[j];
            end
        end
        for (int i = 0; i < n; i++) begin
            cards[i] = (big && i == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
            push_le(64'($urandom_range(0, 65535)), 2);
            push_le(64'(cards[i]), 2);
        end
        if (!run) begin
            off = 32'(8 + 8 * n);
            for (int i = 0; i < n; i++) begin
                push_le(64'((corrupt && i == bad) ? off ^ (32'd1 << $urandom_range(0, 31))
                                                   : off), 4);
                off += (cards[i] >= 16'd4096) ? 32'(BITSET_BYTES) : 2 * (cards[i] + 1);
            end
            push_noise(int'(off) - (8 + 8 * n));
        end else begin
            if (n >= int'(OFFSETS_FROM)) push_noise(4 * n);
            for (int i = 0; i < n; i++) begin
                if (flags[i]) begin
                    nruns = $urandom_range(0, 3);
                    push_le(64'(nruns), 2);
                    push_noise(4 * nruns);
                end else begin
                    bytes = (cards[i] >= 16'd4096) ? int'(BITSET_BYTES) : 2 * (cards[i] + 1);
                    push_noise(bytes);
                end
            end
        end
    endtask

    // Random payload for the current width: mostly well formed, some cut, padded or noise.
    task automatic build_random(input bit wide);
        int keys;
        int pick;
        int len;
        payload.delete();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            push_noise($urandom_range(1, 12));
        end else begin
            if (wide) begin
                keys = $urandom_range(0, 3);
                push_le(64'(keys), 8);
                for (int b = 0; b < keys; b++) begin
                    push_le(64'($urandom), 4);
                    push_bitmap($urandom_range(0, 1), $urandom_range(1, 5),
                                $urandom_range(0, 5) == 0, 1'b0);
                end
            end else begin
                push_bitmap($urandom_range(0, 1), $urandom_range(1, 6),
                            $urandom_range(0, 5) == 0, 1'b0);
            end
            if (pick == 1) begin
                len = $urandom_range(1, payload.size());
                while (payload.size() > len) void'(payload.pop_back());
            end else if (pick == 2) begin
                push_noise($urandom_range(1, 4));
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_payload();
        foreach (payload[k]) send_byte(payload[k], k == payload.size() - 1);
    endtask

    // Cut the current payload to len bytes and send it.
    task automatic send_cut(input int len);
        while (payload.size() > len) void'(payload.pop_back());
        send_payload();
    endtask

    // Register write once the block has drained.
    task automatic set_width(input logic w);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_bitmap_width <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int batch_bytes;
        int batch_count;
        cycles = 0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_bitmap_width <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed 32-bit payloads.
        set_width(1'b0);
        payload.delete(); push_bitmap(1'b0, 0, 1'b0, 1'b0); send_payload();
        payload.delete(); push_le(64'h1234_5678, 4); push_noise(3); send_payload();
        payload.delete(); push_le(64'(COOKIE_NORUN), 4); send_cut(2);
        payload.delete(); push_bitmap(1'b0, 0, 1'b0, 1'b0); send_cut(6);
        payload.delete(); push_le(64'(COOKIE_NORUN), 4); push_le(64'd5000, 4); send_payload();
        payload.delete(); push_le(64'hFFFF_0000 | 64'(COOKIE_RUN), 4); push_noise(2);
        send_payload();
        payload.delete(); push_bitmap(1'b0, 3, 1'b0, 1'b0); send_payload();
        payload.delete(); push_bitmap(1'b0, 3, 1'b1, 1'b0); send_payload();
        payload.delete(); push_bitmap(1'b0, 2, 1'b0, 1'b1); send_payload();
        payload.delete(); push_bitmap(1'b1, 9, 1'b0, 1'b1); send_payload();
        payload.delete(); push_bitmap(1'b1, 2, 1'b0, 1'b0); push_noise(3); send_payload();
        payload.delete(); push_bitmap(1'b1, 5, 1'b0, 1'b0); send_cut(15);
        payload.delete(); push_bitmap(1'b0, 2, 1'b0, 1'b0); send_cut(20);
        payload.delete(); push_bitmap(1'b0, 2, 1'b0, 1'b0); send_cut(26);

        // Directed 64-bit payloads.
        set_width(1'b1);
        payload.delete(); push_le(64'd0, 8); send_payload();
        payload.delete(); push_le(64'd2, 8);
        push_le(64'hFFFF_FFFF, 4); push_bitmap(1'b0, 2, 1'b0, 1'b0);
        push_le(64'd0, 4); push_bitmap(1'b1, 4, 1'b0, 1'b0); send_payload();
        payload.delete(); push_le(64'd1, 8); push_le(64'd7, 4);
        push_bitmap(1'b0, 3, 1'b0, 1'b0); send_cut(30);
        payload.delete(); push_le('1, 8); send_cut(5);
        payload.delete(); push_le('1, 8); push_noise(2); send_payload();
        payload.delete(); push_le(64'd2, 8); push_le(64'd1, 4);
        push_bitmap(1'b0, 2, 1'b1, 1'b0); push_le(64'd2, 4);
        push_bitmap(1'b0, 1, 1'b0, 1'b0); send_payload();

        // Random batches over widths and idle patterns.
        for (int p = 0; p < 8; p++) begin
            set_width(p[0]);
            case (p >> 1)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            if (p == 1) hold_req = 1'b1;
            batch_bytes = 0;
            batch_count = 0;
            while (batch_bytes < 70 || batch_count < 6) begin
                build_random(p[0]);
                send_payload();
                batch_bytes += payload.size();
                batch_count++;
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("roaring_bitmap_compliance_check_top test passed");
        end else begin
            $display("roaring_bitmap_compliance_check_top test failed");
        end
        $finish;
    end

endmodule
